// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

// ===== hdl/ucfh_pkg.sv =====
// Types, codes and constants of the UART command frame handler.
// No dependencies; imported by the core and its checker.
package ucfh_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EXEC,
    ST_DIV,
    ST_LOAD
  } state_t;

  localparam logic [2:0] STAT_OK  = 3'd0;
  localparam logic [2:0] STAT_XOR = 3'd1;
  localparam logic [2:0] STAT_LEN = 3'd2;
  localparam logic [2:0] STAT_CMD = 3'd3;
  localparam logic [2:0] STAT_HDR = 3'd4;

  localparam byte_t CMD_VERSION  = 8'h01;
  localparam byte_t CMD_SET_FREQ = 8'h02;
  localparam byte_t CMD_GET_FREQ = 8'h03;
  localparam byte_t CMD_SET_DUTY = 8'h04;
  localparam byte_t CMD_GET_DUTY = 8'h05;

  localparam byte_t HDR_RX    = 8'hCA;
  localparam byte_t HDR_TX    = 8'hAC;
  localparam byte_t LEN_SHORT = 8'h01;
  localparam byte_t LEN_LONG  = 8'h04;

  localparam logic [8:0] FRAME_EXTRA = 9'd4;

  localparam logic [1:0] CFG_FREQ_MIN = 2'd0;
  localparam logic [1:0] CFG_FREQ_MAX = 2'd1;
  localparam logic [1:0] CFG_DUTY_MAX = 2'd2;
  localparam logic [1:0] CFG_VERSION  = 2'd3;

  localparam logic [15:0] RST_FREQ_MIN = 16'd100;
  localparam logic [15:0] RST_FREQ_MAX = 16'd10000;
  localparam logic [15:0] RST_DUTY_MAX = 16'd100;
  localparam byte_t       RST_VERSION  = 8'h11;

  localparam logic [15:0] K1000 = 16'd1000;
  localparam logic [15:0] K100  = 16'd100;
  localparam logic [15:0] K10   = 16'd10;

  // reciprocals: q = (x * RCP) >> SH, exact for any 16-bit x
  localparam logic [16:0] RCP_1000 = 17'd67109;
  localparam logic [4:0]  SH_1000  = 5'd26;
  localparam logic [16:0] RCP_100  = 17'd83887;
  localparam logic [4:0]  SH_100   = 5'd23;
  // exact for x below 100
  localparam logic [16:0] RCP_10   = 17'd103;
  localparam logic [4:0]  SH_10    = 5'd10;

  // divisor of each digit stage of the decimal readback
  function automatic logic [15:0] div_divisor(logic is_freq, logic [1:0] stage);
    logic [15:0] v;
    if (is_freq) begin
      case (stage)
        2'd0:    v = K1000;
        2'd1:    v = K100;
        default: v = K10;
      endcase
    end else begin
      case (stage)
        2'd0:    v = K100;
        default: v = K10;
      endcase
    end
    return v;
  endfunction

  function automatic logic [16:0] div_recip(logic is_freq, logic [1:0] stage);
    logic [16:0] v;
    case (div_divisor(is_freq, stage))
      K1000:   v = RCP_1000;
      K100:    v = RCP_100;
      default: v = RCP_10;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] div_shift(logic is_freq, logic [1:0] stage);
    logic [4:0] v;
    case (div_divisor(is_freq, stage))
      K1000:   v = SH_1000;
      K100:    v = SH_100;
      default: v = SH_10;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] div_last(logic is_freq);
    return is_freq ? 2'd2 : 2'd1;
  endfunction

endpackage

// ===== hdl/uart_command_frame_handler_core.sv =====
// UART command frame handler core: frame buffer RAM, checker, reciprocal-multiply
// digit unit and reply drain; depends on ucfh_pkg. Byte words give no result.
// After an accepted gap: buffer reads, check, execute, digit unit for a readback,
// load and output register; reply words follow one per cycle unless out_stall holds
// them; bytes stall while a frame is processed, a gap also until the previous reply
// has drained. Sync reset restores defaults, clears counts and settings.
module uart_command_frame_handler_core #(
  parameter int BUF_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  ucfh_pkg::byte_t     rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output ucfh_pkg::byte_t     tx_byte,
  output logic                tx_valid,
  output logic                last,
  output logic [2:0]          check_status,
  output logic [15:0]         freq_value,
  output logic [15:0]         duty_value,
  output logic                freq_updated,
  output logic                duty_updated,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import ucfh_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  state_t state, state_next;

  logic [15:0] freq_min, freq_max, duty_max;
  byte_t       version_byte;
  logic [15:0] freq_setting, duty_setting;

  byte_t       mem [BUF_DEPTH];
  byte_t       mem_rdata;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0] rx_count, frm_count;
  byte_t         running_xor, frm_xor;
  logic [2:0]    rd_idx;
  logic [2:0]    cap_pos;
  byte_t         fb [7];

  logic          in_fire, byte_wr, gap_go;
  logic [2:0]    status, status_next;
  logic [15:0]   part_a, part_b, part_a_next, part_b_next;
  logic [8:0]    len_sum;

  logic          dv_freq;
  logic [15:0]   dv_rem, dv_rem_next;
  logic [9:0]    dv_quo, dv_quo_next;
  logic          dv_half;
  logic [1:0]    dv_stage;
  logic [32:0]   dv_prod;
  logic [9:0]    dg [4];

  byte_t         dbyte [8];
  byte_t         rep_next [8];
  byte_t         rep [8];
  byte_t         rep_x;
  logic [3:0]    n_data;
  logic [3:0]    rep_len;
  logic [2:0]    rep_idx;
  logic [2:0]    rep_status;
  logic          rep_ok, rep_fu, rep_du, rep_busy;
  logic          out_adv;

  assign in_fire = in_valid && !in_stall;
  assign byte_wr = in_fire && !func && (rx_count < CW'(BUF_DEPTH));
  assign gap_go  = in_fire && func && (rx_count != '0);
  assign cap_pos = rd_idx - 3'd1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (gap_go) state_next = ST_READ;
      ST_READ:  if (rd_idx == 3'd7) state_next = ST_CHECK;
      ST_CHECK: state_next = ST_EXEC;
      ST_EXEC: begin
        if (status != STAT_OK) begin
          state_next = ST_LOAD;
        end else if (fb[1] == CMD_GET_FREQ || fb[1] == CMD_GET_DUTY) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_DIV:   if (dv_half && dv_stage == div_last(dv_freq)) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = (state != ST_IDLE) || (func && rep_busy);
    rd_addr  = AW'(rd_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_min     <= RST_FREQ_MIN;
      freq_max     <= RST_FREQ_MAX;
      duty_max     <= RST_DUTY_MAX;
      version_byte <= RST_VERSION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FREQ_MIN: freq_min     <= cfg_data;
        CFG_FREQ_MAX: freq_max     <= cfg_data;
        CFG_DUTY_MAX: duty_max     <= cfg_data;
        CFG_VERSION:  version_byte <= cfg_data[7:0];
        default:      ;
      endcase
    end
  end

  // frame buffer
  always_ff @(posedge clk) begin
    if (byte_wr) begin
      mem[rx_count[AW-1:0]] <= rx_byte;
    end
    mem_rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count    <= '0;
      running_xor <= '0;
    end else if (in_fire && func) begin
      rx_count    <= '0;
      running_xor <= '0;
    end else if (byte_wr) begin
      rx_count    <= rx_count + CW'(1);
      running_xor <= running_xor ^ rx_byte;
    end
  end

  // header capture
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (gap_go) begin
      rd_idx <= '0;
    end else if (state == ST_READ) begin
      rd_idx <= rd_idx + 3'd1;
    end
    if (gap_go) begin
      frm_count <= rx_count;
      frm_xor   <= running_xor;
    end
    if (state == ST_READ && rd_idx != 3'd0) begin
      fb[cap_pos] <= (CW'(cap_pos) < frm_count) ? mem_rdata : 8'h00;
    end
  end

  // frame check and decimal partial sums
  always_comb begin
    len_sum = {1'b0, fb[2]} + FRAME_EXTRA;
    if (fb[0] != HDR_RX) begin
      status_next = STAT_HDR;
    end else if (fb[1] < CMD_VERSION || fb[1] > CMD_GET_DUTY) begin
      status_next = STAT_CMD;
    end else if (len_sum != 9'(frm_count)) begin
      status_next = STAT_LEN;
    end else if (frm_xor != 8'h00) begin
      status_next = STAT_XOR;
    end else begin
      status_next = STAT_OK;
    end
    if (fb[1] == CMD_SET_FREQ) begin
      part_a_next = {8'h00, fb[3]} * K1000 + {8'h00, fb[4]} * K100;
      part_b_next = {8'h00, fb[5]} * K10 + {8'h00, fb[6]};
    end else begin
      part_a_next = {8'h00, fb[3]} * K100 + {8'h00, fb[4]} * K10;
      part_b_next = {8'h00, fb[5]};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      status <= status_next;
      part_a <= part_a_next;
      part_b <= part_b_next;
    end
  end

  // settings
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_setting <= '0;
      duty_setting <= '0;
    end else if (state == ST_EXEC && status == STAT_OK) begin
      if (fb[1] == CMD_SET_FREQ) freq_setting <= part_a + part_b;
      if (fb[1] == CMD_SET_DUTY) duty_setting <= part_a + part_b;
    end
  end

  // digit unit: reciprocal multiply for the quotient, then the remainder
  always_comb begin
    dv_prod     = {17'b0, dv_rem} * {16'b0, div_recip(dv_freq, dv_stage)};
    dv_quo_next = 10'(dv_prod >> div_shift(dv_freq, dv_stage));
    dv_rem_next = dv_rem - ({6'b0, dv_quo} * div_divisor(dv_freq, dv_stage));
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      dv_freq  <= (fb[1] == CMD_GET_FREQ);
      dv_rem   <= (fb[1] == CMD_GET_FREQ) ? freq_setting : duty_setting;
      dv_stage <= 2'd0;
      dv_half  <= 1'b0;
    end else if (state == ST_DIV) begin
      if (!dv_half) begin
        dv_quo  <= dv_quo_next;
        dv_half <= 1'b1;
      end else begin
        dv_rem       <= dv_rem_next;
        dv_half      <= 1'b0;
        dg[dv_stage] <= dv_quo;
        if (dv_stage == div_last(dv_freq)) begin
          dg[dv_stage + 2'd1] <= dv_rem_next[9:0];
        end else begin
          dv_stage <= dv_stage + 2'd1;
        end
      end
    end
  end

  // reply build
  always_comb begin
    for (int i = 0; i < 8; i++) dbyte[i] = 8'h00;
    dbyte[0] = HDR_TX;
    dbyte[1] = fb[1];
    n_data   = 4'd4;
    case (fb[1])
      CMD_VERSION: begin
        dbyte[2] = LEN_SHORT;
        dbyte[3] = version_byte;
      end
      CMD_SET_FREQ: begin
        dbyte[2] = LEN_SHORT;
        dbyte[3] = {7'b0, (freq_setting >= freq_min) && (freq_setting <= freq_max)};
      end
      CMD_GET_FREQ: begin
        dbyte[2] = LEN_LONG;
        dbyte[3] = dg[0][7:0];
        dbyte[4] = dg[1][7:0];
        dbyte[5] = dg[2][7:0];
        dbyte[6] = dg[3][7:0];
        n_data   = 4'd7;
      end
      CMD_SET_DUTY: begin
        dbyte[2] = LEN_SHORT;
        dbyte[3] = {7'b0, duty_setting <= duty_max};
      end
      default: begin
        dbyte[2] = LEN_LONG;
        dbyte[3] = dg[0][7:0];
        dbyte[4] = dg[1][7:0];
        dbyte[5] = dg[2][7:0];
        n_data   = 4'd6;
      end
    endcase
    rep_x = 8'h00;
    for (int i = 0; i < 8; i++) rep_x = rep_x ^ dbyte[i];
    for (int i = 0; i < 8; i++) begin
      rep_next[i] = (4'(i) == n_data) ? rep_x : dbyte[i];
    end
  end

  // reply drain and output register
  assign out_adv = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      rep_idx    <= '0;
      rep_status <= status;
      rep_ok     <= (status == STAT_OK);
      rep_fu     <= (status == STAT_OK) && (fb[1] == CMD_SET_FREQ);
      rep_du     <= (status == STAT_OK) && (fb[1] == CMD_SET_DUTY);
      if (status == STAT_OK) begin
        for (int i = 0; i < 8; i++) rep[i] <= rep_next[i];
        rep_len <= n_data + 4'd1;
      end else begin
        rep[0]  <= 8'h00;
        rep_len <= 4'd1;
      end
    end else if (out_adv && rep_busy) begin
      rep_idx <= rep_idx + 3'd1;
    end
    if (out_adv && rep_busy) begin
      tx_byte      <= rep[rep_idx];
      tx_valid     <= rep_ok;
      last         <= ({1'b0, rep_idx} == rep_len - 4'd1);
      check_status <= rep_status;
      freq_value   <= freq_setting;
      duty_value   <= duty_setting;
      freq_updated <= rep_fu;
      duty_updated <= rep_du;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_busy  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_LOAD) begin
        rep_busy <= 1'b1;
      end else if (out_adv && rep_busy && ({1'b0, rep_idx} == rep_len - 4'd1)) begin
        rep_busy <= 1'b0;
      end
      if (out_adv) begin
        out_valid <= rep_busy;
      end
    end
  end

endmodule

// ===== hdl/ucfh_checker.sv =====
// Port-level checker for the UART command frame handler core.
// Depends on ucfh_pkg and assert_macros.svh; bound to the core below.
`include "assert_macros.svh"

module ucfh_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_stall,
  input ucfh_pkg::byte_t tx_byte,
  input logic            tx_valid,
  input logic            last,
  input logic [2:0]      check_status,
  input logic            freq_updated,
  input logic            duty_updated
);
  import ucfh_pkg::*;

  `ASSERT_NOW(a_err_single, out_valid && !tx_valid, last && (check_status != STAT_OK) && !freq_updated && !duty_updated)
  `ASSERT_NOW(a_ok_status, out_valid && tx_valid, check_status == STAT_OK)
  `ASSERT_NOW(a_one_update, out_valid && (freq_updated || duty_updated), tx_valid && !(freq_updated && duty_updated))
  `ASSERT_NEXT(a_hold_word, out_valid && out_stall, out_valid && $stable(tx_byte) && $stable(last))

endmodule

bind uart_command_frame_handler_core ucfh_checker u_ucfh_checker (.*);

// ===== sim/ucfh_reply_checker.sv =====
`timescale 1ns / 1ps
// Reply checker for the UART command frame handler: tracks the frame buffer,
// the settings and the registers, predicts each reply word and compares it.
// Depends on ucfh_pkg.
module ucfh_reply_checker #(
  parameter int BUF_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic            func,
  input  ucfh_pkg::byte_t rx_byte,
  input  logic            out_valid,
  input  logic            out_stall,
  input  ucfh_pkg::byte_t tx_byte,
  input  logic            tx_valid,
  input  logic            last,
  input  logic [2:0]      check_status,
  input  logic [15:0]     freq_value,
  input  logic [15:0]     duty_value,
  input  logic            freq_updated,
  input  logic            duty_updated,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output int              fail_count,
  output int              pending
);
  import ucfh_pkg::*;

  localparam logic FUNC_GAP  = 1'b1;
  localparam int   PRINT_CAP = 200;

  typedef struct {
    byte_t       data;
    logic        data_valid;
    logic        is_last;
    logic [2:0]  status;
    logic [15:0] freq;
    logic [15:0] duty;
    logic        freq_wr;
    logic        duty_wr;
  } reply_word_t;

  reply_word_t reply_q[$];
  byte_t       frame_mem [BUF_DEPTH];
  int          frame_len;
  byte_t       frame_xor;
  logic [15:0] freq_lo, freq_hi, duty_hi;
  logic [15:0] freq_set, duty_set;
  byte_t       version;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    if (fail_count < PRINT_CAP) $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic match(input string field, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report($sformatf("%s is %h, predicted %h", field, got, want));
  endtask

  // positions past the received count read as zero
  function automatic int frame_byte(input int pos);
    return (pos < frame_len) ? int'(frame_mem[pos]) : 0;
  endfunction

  task automatic push_word(input byte_t d, input logic v, input logic l,
                           input logic [2:0] st, input logic fw, input logic dw);
    reply_word_t w;
    w.data = d;
    w.data_valid = v;
    w.is_last = l;
    w.status = st;
    w.freq = freq_set;
    w.duty = duty_set;
    w.freq_wr = fw;
    w.duty_wr = dw;
    reply_q.push_back(w);
  endtask

  task automatic close_frame();
    byte_t      cmd, chk;
    byte_t      rep [8];
    logic [2:0] st;
    logic       fw, dw;
    int         n, acc;
    if (frame_len == 0) return;
    fw = 1'b0;
    dw = 1'b0;
    n = 0;
    chk = 8'h00;
    cmd = byte_t'(frame_byte(1));
    if (frame_byte(0) != HDR_RX) st = STAT_HDR;
    else if (cmd < CMD_VERSION || cmd > CMD_GET_DUTY) st = STAT_CMD;
    else if (frame_byte(2) + int'(FRAME_EXTRA) != frame_len) st = STAT_LEN;
    else if (frame_xor != 8'h00) st = STAT_XOR;
    else st = STAT_OK;
    if (st == STAT_OK) begin
      rep[0] = HDR_TX;
      rep[1] = cmd;
      case (cmd)
        CMD_VERSION: begin
          rep[2] = LEN_SHORT;
          rep[3] = version;
          n = 4;
        end
        CMD_SET_FREQ: begin
          acc = frame_byte(3) * 1000 + frame_byte(4) * 100 + frame_byte(5) * 10
                + frame_byte(6);
          freq_set = 16'(acc);
          fw = 1'b1;
          rep[2] = LEN_SHORT;
          rep[3] = (freq_set >= freq_lo && freq_set <= freq_hi) ? 8'd1 : 8'd0;
          n = 4;
        end
        CMD_GET_FREQ: begin
          rep[2] = LEN_LONG;
          rep[3] = byte_t'(freq_set / 1000);
          rep[4] = byte_t'((freq_set % 1000) / 100);
          rep[5] = byte_t'((freq_set % 100) / 10);
          rep[6] = byte_t'(freq_set % 10);
          n = 7;
        end
        CMD_SET_DUTY: begin
          acc = frame_byte(3) * 100 + frame_byte(4) * 10 + frame_byte(5);
          duty_set = 16'(acc);
          dw = 1'b1;
          rep[2] = LEN_SHORT;
          rep[3] = (duty_set <= duty_hi) ? 8'd1 : 8'd0;
          n = 4;
        end
        default: begin
          rep[2] = LEN_LONG;
          rep[3] = byte_t'(duty_set / 100);
          rep[4] = byte_t'((duty_set % 100) / 10);
          rep[5] = byte_t'(duty_set % 10);
          n = 6;
        end
      endcase
      for (int i = 0; i < n; i++) chk ^= rep[i];
      rep[n] = chk;
      n++;
    end
    frame_len = 0;
    frame_xor = 8'h00;
    if (st != STAT_OK) begin
      push_word(8'h00, 1'b0, 1'b1, st, 1'b0, 1'b0);
    end else begin
      for (int i = 0; i < n; i++) push_word(rep[i], 1'b1, i == n - 1, STAT_OK, fw, dw);
    end
  endtask

  task automatic check_word();
    reply_word_t w;
    if (reply_q.size() == 0) begin
      report($sformatf("reply word %h with nothing pending", tx_byte));
      return;
    end
    w = reply_q.pop_front();
    match("tx_byte", tx_byte, w.data);
    match("tx_valid", tx_valid, w.data_valid);
    match("last", last, w.is_last);
    match("check_status", check_status, w.status);
    match("freq_value", freq_value, w.freq);
    match("duty_value", duty_value, w.duty);
    match("freq_updated", freq_updated, w.freq_wr);
    match("duty_updated", duty_updated, w.duty_wr);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_len = 0;
      frame_xor = 8'h00;
      freq_set = 16'h0000;
      duty_set = 16'h0000;
      freq_lo = RST_FREQ_MIN;
      freq_hi = RST_FREQ_MAX;
      duty_hi = RST_DUTY_MAX;
      version = RST_VERSION;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FREQ_MIN: freq_lo = cfg_data;
          CFG_FREQ_MAX: freq_hi = cfg_data;
          CFG_DUTY_MAX: duty_hi = cfg_data;
          CFG_VERSION:  version = cfg_data[7:0];
        endcase
      end
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) begin
        if (func == FUNC_GAP) begin
          close_frame();
        end else if (frame_len < BUF_DEPTH) begin
          frame_mem[frame_len] = rx_byte;
          frame_len++;
          frame_xor ^= rx_byte;
        end
      end
    end
    pending = reply_q.size();
  end

endmodule

// ===== sim/tb_uart_command_frame_handler_core.sv =====
`timescale 1ns / 1ps
// Testbench top for uart_command_frame_handler_core: drives command frames,
// broken frames, noise and register writes with random idling; gives the verdict.
// Depends on ucfh_pkg, ucfh_reply_checker and the core.
module tb_uart_command_frame_handler_core;
  import ucfh_pkg::*;

  localparam int   BUF_DEPTH   = 32;
  localparam int   STALL_LIMIT = 2000;
  localparam int   SETTLE      = 40;
  localparam int   PHASE_WORDS = 100;
  localparam logic FUNC_BYTE   = 1'b0;
  localparam logic FUNC_GAP    = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        func = FUNC_BYTE;
  byte_t       rx_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FREQ_MIN;
  logic [15:0] cfg_data = 16'h0000;

  logic        in_stall, out_valid, tx_valid, last, freq_updated, duty_updated;
  byte_t       tx_byte;
  logic [2:0]  check_status;
  logic [15:0] freq_value, duty_value;
  int          fail_count, pending;

  byte_t frame_q[$];
  int    words_sent = 0;
  int    idle_pct = 0;
  int    out_hold = 0;
  int    quiet_cycles = 0;

  uart_command_frame_handler_core #(.BUF_DEPTH(BUF_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .tx_byte(tx_byte),
    .tx_valid(tx_valid), .last(last), .check_status(check_status),
    .freq_value(freq_value), .duty_value(duty_value),
    .freq_updated(freq_updated), .duty_updated(duty_updated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ucfh_reply_checker #(.BUF_DEPTH(BUF_DEPTH)) reply_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .tx_byte(tx_byte),
    .tx_valid(tx_valid), .last(last), .check_status(check_status),
    .freq_value(freq_value), .duty_value(duty_value),
    .freq_updated(freq_updated), .duty_updated(duty_updated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (out_hold == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct)
      out_hold = $urandom_range(17, 1);
    if (out_hold != 0) begin
      out_stall <= 1'b1;
      out_hold = out_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_word(input logic f, input byte_t b);
    in_valid <= 1'b1;
    func <= f;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_word(FUNC_BYTE, frame_q[i]);
    send_word(FUNC_GAP, byte_t'($urandom_range(255)));
  endtask

  task automatic start_frame(input byte_t cmd, input int len);
    frame_q.delete();
    frame_q.push_back(HDR_RX);
    frame_q.push_back(cmd);
    frame_q.push_back(byte_t'(len));
  endtask

  task automatic seal_frame();
    byte_t x;
    x = 8'h00;
    foreach (frame_q[i]) x ^= frame_q[i];
    frame_q.push_back(x);
  endtask

  task automatic directed_frame(input byte_t cmd, input int len, input byte_t fill);
    start_frame(cmd, len);
    repeat (len) frame_q.push_back(fill);
    seal_frame();
    send_frame();
  endtask

  task automatic random_frame();
    int    pick, len, target;
    byte_t cmd;
    pick = $urandom_range(99);
    cmd = byte_t'($urandom_range(CMD_GET_DUTY, CMD_VERSION));
    case (cmd)
      CMD_SET_FREQ: len = 4;
      CMD_SET_DUTY: len = 3;
      default:      len = 0;
    endcase
    if ($urandom_range(4) == 0) len = $urandom_range(BUF_DEPTH - 4);
    start_frame(cmd, len);
    repeat (len)
      frame_q.push_back(byte_t'(($urandom_range(7) == 0) ? $urandom_range(255)
                                                         : $urandom_range(9)));
    if (pick >= 60 && pick < 67) begin
      frame_q[0] = HDR_RX ^ byte_t'($urandom_range(255, 1));
    end else if (pick >= 67 && pick < 74) begin
      frame_q[1] = ($urandom_range(3) == 0) ? 8'h00
                                            : byte_t'($urandom_range(255, CMD_GET_DUTY + 1));
    end else if (pick >= 74 && pick < 81) begin
      frame_q[2] = frame_q[2] ^ byte_t'($urandom_range(255, 1));
    end
    seal_frame();
    if (pick >= 81 && pick < 88) begin
      frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ byte_t'($urandom_range(255, 1));
    end else if (pick >= 88 && pick < 92) begin
      target = BUF_DEPTH + 1 + $urandom_range(7);
      while (frame_q.size() < target) frame_q.push_back(byte_t'($urandom_range(255)));
    end else if (pick >= 92 && pick < 95) begin
      frame_q.delete();
    end else if (pick >= 95) begin
      frame_q.delete();
      repeat ($urandom_range(12, 1)) frame_q.push_back(byte_t'($urandom_range(255)));
    end
    send_frame();
  endtask

  // hold the sender until every reply is in, then let the core go idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] fmin, input logic [15:0] fmax,
                              input logic [15:0] dmax, input logic [15:0] ver);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FREQ_MIN;
    cfg_data <= fmin;
    @(posedge clk);
    cfg_index <= CFG_FREQ_MAX;
    cfg_data <= fmax;
    @(posedge clk);
    cfg_index <= CFG_DUTY_MAX;
    cfg_data <= dmax;
    @(posedge clk);
    cfg_index <= CFG_VERSION;
    cfg_data <= ver;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    directed_frame(CMD_SET_FREQ, 4, 8'hFF);
    directed_frame(CMD_GET_FREQ, 0, 8'h00);
    directed_frame(CMD_SET_DUTY, 3, 8'hFF);
    directed_frame(CMD_GET_DUTY, 0, 8'h00);
    directed_frame(CMD_VERSION, 0, 8'h00);
    frame_q.delete();
    send_frame();
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_config(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
          idle_pct = 10;
        end
        1: begin
          write_config(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
          idle_pct = 25;
        end
        2: begin
          write_config(16'($urandom_range(2000)), 16'($urandom_range(9999, 2000)),
                       16'($urandom_range(300)), 16'($urandom_range(65535)));
          idle_pct = 5;
        end
        default: begin
          write_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                       16'($urandom_range(65535)), 16'($urandom_range(65535)));
          idle_pct = 0;
        end
      endcase
      words_sent = 0;
      while (words_sent < PHASE_WORDS) random_frame();
      drain();
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
